[design/gb3_pkg.sv]
// shared types, constants and register codes for the 3x3 gaussian blur stream
`default_nettype none
package gb3_pkg;

	localparam int MAX_WIDTH_DEFAULT  = 1024;
	localparam int PIXEL_W            = 8;
	localparam int RESULT_W           = 12;
	localparam int FRAME_WIDTH_W      = 11;
	localparam int FRAME_HEIGHT_W     = 16;
	localparam int CFG_IDX_W          = 1;
	localparam int CFG_DATA_W         = 16;
	localparam int FRAME_WIDTH_RESET  = 640;
	localparam int FRAME_HEIGHT_RESET = 480;
	// smallest frame side, and distance from the newest window pixel to the far corner
	localparam int MIN_SIDE           = 3;
	localparam int WIN_REACH          = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	typedef logic [PIXEL_W-1:0]  pixel_t;
	typedef logic [RESULT_W-1:0] result_t;

	// one line store entry: pixel two rows up and pixel one row up
	typedef struct packed {
		pixel_t upper;
		pixel_t middle;
	} line_pair_t;

endpackage
`default_nettype wire

[design/gaussian_blur_3x3_stream.sv]
// Streaming 3x3 gaussian blur, kernel 1-2-1 by 1-2-1, result in 8.4 fixed point.
// Pixels enter in raster order on in_valid / in_stall with pixel as the beat.
// Each interior pixel gives one beat on out_valid / out_stall carrying
// filtered_value (sum of weighted window, value / 16) and frame_last, which
// marks the last interior pixel of a frame. Border pixels give no beat.
// Frame size comes from cfg_we / cfg_index / cfg_data: index 0 is the width
// (3..MAX_WIDTH), index 1 the height (3..65535). Any write restarts the frame;
// write only while the block is idle.
// Throughput is one pixel per cycle unless out_stall holds an interior pixel.
// The line store read happens at the edge that takes a pixel, and the window
// sum is registered from pixel_s1 into result_q, from which it is offered.
// Line store read and write-back go to different columns in any cycle, since a
// column is revisited only after a whole row.
// After reset the frame is 640 x 480 (width capped at MAX_WIDTH), the
// position is at the frame start and the window is zero.
// While out_stall holds a waiting result, border pixels still pass and one
// interior pixel is held behind it; in_stall then rises until out_stall drops.
`default_nettype none
module gaussian_blur_3x3_stream
	import gb3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIXEL_W-1:0]    pixel,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [RESULT_W-1:0]        filtered_value,
	output logic                       frame_last
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic             accept;
	logic             s1_move;
	logic             out_free;
	logic [COL_W-1:0] pos_col;
	logic             pos_emit;
	logic             pos_last;
	line_pair_t       rd_data;
	line_pair_t       wr_data;
	result_t          next_sum;

	logic             s1_valid_q;
	pixel_t           pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	logic             last_s1;

	logic             out_valid_q;
	result_t          result_q;
	logic             last_q;

	assign out_free = !out_valid_q || !out_stall;
	// a border pixel needs no output slot to move on
	assign s1_move  = s1_valid_q && (!emit_s1 || out_free);
	assign in_stall = s1_valid_q && !s1_move;
	assign accept   = in_valid && !in_stall;

	gb3_pos #(
		.MAX_WIDTH(MAX_WIDTH),
		.COL_W    (COL_W)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (accept),
		.col      (pos_col),
		.emit     (pos_emit),
		.last     (pos_last)
	);

	// upper store takes the old middle row, middle store takes the new pixel
	assign wr_data.upper  = rd_data.middle;
	assign wr_data.middle = pixel_s1;

	gb3_line_mem #(
		.DEPTH (MAX_WIDTH),
		.ADDR_W(COL_W)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(pos_col),
		.rd_data(rd_data),
		.wr_en  (s1_move),
		.wr_addr(col_s1),
		.wr_data(wr_data)
	);

	gb3_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (s1_move),
		.top     (rd_data.upper),
		.mid     (rd_data.middle),
		.pix     (pixel_s1),
		.next_sum(next_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			col_s1   <= pos_col;
			emit_s1  <= pos_emit;
			last_s1  <= pos_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && emit_s1) begin
			result_q <= next_sum;
			last_q   <= last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = result_q;
	assign frame_last     = last_q;

endmodule
`default_nettype wire

[design/gb3_line_mem.sv]
// two line stores held side by side in one synchronous memory
`default_nettype none
module gb3_line_mem
	import gb3_pkg::*;
#(
	parameter int DEPTH  = MAX_WIDTH_DEFAULT,
	parameter int ADDR_W = $clog2(MAX_WIDTH_DEFAULT)
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output line_pair_t             rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire line_pair_t        wr_data
);

	line_pair_t mem [DEPTH];
	line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[design/gb3_pos.sv]
// frame geometry registers and the column / row position of the next pixel
`default_nettype none
module gb3_pos
	import gb3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
	parameter int COL_W     = $clog2(MAX_WIDTH_DEFAULT)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  advance,
	output logic [COL_W-1:0]           col,
	output logic                       emit,
	output logic                       last
);

	localparam int CMP_W = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;
	localparam int RST_W_EFF = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
		: FRAME_WIDTH_RESET;
	localparam logic [COL_W-1:0] RST_LAST_COL = COL_W'(RST_W_EFF - 1);
	localparam logic [FRAME_HEIGHT_W-1:0] RST_LAST_ROW =
		FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET - 1);

	logic [COL_W-1:0]          col_q;
	logic [FRAME_HEIGHT_W-1:0] row_q;
	logic [COL_W-1:0]          last_col_q;
	logic [FRAME_HEIGHT_W-1:0] last_row_q;
	logic [CMP_W-1:0]          fw_ext;
	logic [COL_W-1:0]          last_col_new;
	logic [FRAME_HEIGHT_W-1:0] fh;
	logic [FRAME_HEIGHT_W-1:0] last_row_new;

	// clamp width to 3..MAX_WIDTH and height to at least 3
	always_comb begin
		fw_ext = CMP_W'(cfg_data[FRAME_WIDTH_W-1:0]);
		if (fw_ext < CMP_W'(MIN_SIDE)) begin
			last_col_new = COL_W'(MIN_SIDE - 1);
		end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
			last_col_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col_new = COL_W'(fw_ext - CMP_W'(1));
		end
		fh = cfg_data[FRAME_HEIGHT_W-1:0];
		if (fh < FRAME_HEIGHT_W'(MIN_SIDE)) begin
			last_row_new = FRAME_HEIGHT_W'(MIN_SIDE - 1);
		end else begin
			last_row_new = fh - FRAME_HEIGHT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			last_col_q <= RST_LAST_COL;
			last_row_q <= RST_LAST_ROW;
		end else if (cfg_we) begin
			// any write restarts the frame
			col_q <= '0;
			row_q <= '0;
			case (cfg_index)
				CFG_FRAME_WIDTH:  last_col_q <= last_col_new;
				CFG_FRAME_HEIGHT: last_row_q <= last_row_new;
				default:          ;
			endcase
		end else if (advance) begin
			if (col_q >= last_col_q) begin
				col_q <= '0;
				if (row_q >= last_row_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + FRAME_HEIGHT_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign col  = col_q;
	assign emit = (row_q >= FRAME_HEIGHT_W'(WIN_REACH)) && (col_q >= COL_W'(WIN_REACH));
	assign last = (row_q >= last_row_q) && (col_q >= last_col_q);

`ifndef SYNTH
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col_q) else $error("column past end of row");
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= last_row_q) else $error("row past end of frame");
	a_last_is_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> emit) else $error("frame end on a border pixel");
`endif

endmodule
`default_nettype wire

[design/gb3_window.sv]
// 3x3 window registers and the 1-2-1 by 1-2-1 weighted sum of the shifted window
`default_nettype none
module gb3_window
	import gb3_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire pixel_t top,
	input  wire pixel_t mid,
	input  wire pixel_t pix,
	output result_t     next_sum
);

	pixel_t win_q [3][3];
	pixel_t nw    [3][3];

	// window as it stands after this shift; column 2 is the newest
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nw[r][0] = win_q[r][1];
			nw[r][1] = win_q[r][2];
		end
		nw[0][2] = top;
		nw[1][2] = mid;
		nw[2][2] = pix;
		next_sum = RESULT_W'(nw[0][0]) + RESULT_W'(nw[0][2])
			+ RESULT_W'(nw[2][0]) + RESULT_W'(nw[2][2])
			+ ((RESULT_W'(nw[0][1]) + RESULT_W'(nw[1][0])
			+ RESULT_W'(nw[1][2]) + RESULT_W'(nw[2][1])) << 1)
			+ (RESULT_W'(nw[1][1]) << 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (shift) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= nw[r][c];
				end
			end
		end
	end

endmodule
`default_nettype wire
